// ===== hw/rtl/spcd_pkg.sv =====
// spcd_pkg: shared types and constants for the crc-8 checked packet deframer
// used by spcd_crc8, sensor_packet_crc8_deframer and spcd_checker
`timescale 1ns / 1ps

package spcd_pkg;

  // crc-8 settings: poly x^8+x^2+x+1, msb first, init 0
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_TOP_BIT = 8'h80;
  localparam logic [7:0] CRC_INIT    = 8'h00;

  // packet layout
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_TIME_B0 = 4'd0;
  localparam logic [IDX_W-1:0] IDX_TIME_B1 = 4'd1;
  localparam logic [IDX_W-1:0] IDX_TIME_B2 = 4'd2;
  localparam logic [IDX_W-1:0] IDX_TIME_B3 = 4'd3;
  localparam logic [IDX_W-1:0] IDX_FORCE_LO = 4'd4;
  localparam logic [IDX_W-1:0] IDX_FORCE_HI = 4'd5;
  localparam logic [IDX_W-1:0] IDX_ROLL_LO = 4'd6;
  localparam logic [IDX_W-1:0] IDX_ROLL_HI = 4'd7;
  localparam logic [IDX_W-1:0] IDX_PITCH_LO = 4'd8;
  localparam logic [IDX_W-1:0] IDX_PITCH_HI = 4'd9;
  localparam logic [IDX_W-1:0] IDX_BATTERY = 4'd10;
  localparam logic [IDX_W-1:0] CRC_SPAN    = 4'd11;
  localparam logic [IDX_W-1:0] PACKET_LEN  = 4'd12;
  localparam logic [IDX_W-1:0] INDEX_LIMIT = 4'd13;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/spcd_crc8.sv =====
// spcd_crc8: one-byte crc-8 update, eight bit steps unrolled
// depends on spcd_pkg for the polynomial
`timescale 1ns / 1ps

module spcd_crc8 (
  input  logic [7:0] crc,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  // xor in the byte, then shift out eight bits msb first
  always_comb begin
    logic [7:0] acc;
    acc = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((acc & spcd_pkg::CRC_TOP_BIT) != 8'h00) begin
        acc = {acc[6:0], 1'b0} ^ spcd_pkg::CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

// ===== hw/rtl/sensor_packet_crc8_deframer.sv =====
// sensor_packet_crc8_deframer: byte-wide packet deframer with crc-8 check
// depends on spcd_pkg and spcd_crc8
//
//   channel  handshake             payload
//   input    in_valid / in_ready   data_byte, end_of_packet
//   output   out_valid / out_ready status, time_ms, force_tenths, roll_tenths,
//                                  pitch_tenths, battery_level
//
// one item per cycle if not stalled; result valid the cycle after last byte
// the packet state registers and the output register bound the single pass
// in_ready is low only while a result waits and out_ready is low
// synchronous reset clears packet state and the output valid flag
`timescale 1ns / 1ps

module sensor_packet_crc8_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_packet,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        time_ms,
  output logic signed [15:0] force_tenths,
  output logic signed [15:0] roll_tenths,
  output logic signed [15:0] pitch_tenths,
  output logic [7:0]         battery_level
);

  // packet state
  logic [spcd_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]  running_crc, running_crc_next;
  logic        crc_matches, crc_matches_next;
  logic [31:0] time_field, time_field_next;
  logic [15:0] force_field, force_field_next;
  logic [15:0] roll_field, roll_field_next;
  logic [15:0] pitch_field, pitch_field_next;
  logic [7:0]  battery_field, battery_field_next;

  logic [7:0]  crc_step;
  logic        in_fire;
  spcd_pkg::status_t status_next;

  // output register
  spcd_pkg::status_t status_reg;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  spcd_crc8 u_crc8 (
    .crc     (running_crc),
    .data    (data_byte),
    .crc_out (crc_step)
  );

  // per-byte field and crc update
  always_comb begin
    running_crc_next   = running_crc;
    crc_matches_next   = crc_matches;
    time_field_next    = time_field;
    force_field_next   = force_field;
    roll_field_next    = roll_field;
    pitch_field_next   = pitch_field;
    battery_field_next = battery_field;
    if (byte_index < spcd_pkg::CRC_SPAN) begin
      running_crc_next = crc_step;
    end
    unique case (byte_index)
      spcd_pkg::IDX_TIME_B0:  time_field_next[7:0]    = data_byte;
      spcd_pkg::IDX_TIME_B1:  time_field_next[15:8]   = data_byte;
      spcd_pkg::IDX_TIME_B2:  time_field_next[23:16]  = data_byte;
      spcd_pkg::IDX_TIME_B3:  time_field_next[31:24]  = data_byte;
      spcd_pkg::IDX_FORCE_LO: force_field_next[7:0]   = data_byte;
      spcd_pkg::IDX_FORCE_HI: force_field_next[15:8]  = data_byte;
      spcd_pkg::IDX_ROLL_LO:  roll_field_next[7:0]    = data_byte;
      spcd_pkg::IDX_ROLL_HI:  roll_field_next[15:8]   = data_byte;
      spcd_pkg::IDX_PITCH_LO: pitch_field_next[7:0]   = data_byte;
      spcd_pkg::IDX_PITCH_HI: pitch_field_next[15:8]  = data_byte;
      spcd_pkg::IDX_BATTERY:  battery_field_next      = data_byte;
      spcd_pkg::CRC_SPAN:     crc_matches_next = (data_byte == running_crc);
      default: ;
    endcase
    if (byte_index < spcd_pkg::INDEX_LIMIT) begin
      byte_index_next = byte_index + 1'b1;
    end else begin
      byte_index_next = byte_index;
    end
  end

  // verdict on the final byte: length first, then crc
  always_comb begin
    if (byte_index_next != spcd_pkg::PACKET_LEN) begin
      status_next = spcd_pkg::STATUS_LEN_ERR;
    end else if (!crc_matches_next) begin
      status_next = spcd_pkg::STATUS_CRC_ERR;
    end else begin
      status_next = spcd_pkg::STATUS_OK;
    end
  end

  // packet state registers, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      running_crc   <= spcd_pkg::CRC_INIT;
      crc_matches   <= 1'b0;
      time_field    <= '0;
      force_field   <= '0;
      roll_field    <= '0;
      pitch_field   <= '0;
      battery_field <= '0;
    end else if (in_fire) begin
      if (end_of_packet) begin
        byte_index    <= '0;
        running_crc   <= spcd_pkg::CRC_INIT;
        crc_matches   <= 1'b0;
        time_field    <= '0;
        force_field   <= '0;
        roll_field    <= '0;
        pitch_field   <= '0;
        battery_field <= '0;
      end else begin
        byte_index    <= byte_index_next;
        running_crc   <= running_crc_next;
        crc_matches   <= crc_matches_next;
        time_field    <= time_field_next;
        force_field   <= force_field_next;
        roll_field    <= roll_field_next;
        pitch_field   <= pitch_field_next;
        battery_field <= battery_field_next;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_packet) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, fields zeroed on a failed packet
  always_ff @(posedge clk) begin
    if (in_fire && end_of_packet) begin
      status_reg <= status_next;
      if (status_next == spcd_pkg::STATUS_OK) begin
        time_ms       <= time_field_next;
        force_tenths  <= force_field_next;
        roll_tenths   <= roll_field_next;
        pitch_tenths  <= pitch_field_next;
        battery_level <= battery_field_next;
      end else begin
        time_ms       <= '0;
        force_tenths  <= '0;
        roll_tenths   <= '0;
        pitch_tenths  <= '0;
        battery_level <= '0;
      end
    end
  end

  assign status = status_reg;

endmodule

// ===== hw/rtl/spcd_checker.sv =====
// spcd_assertions: port-level assertions for sensor_packet_crc8_deframer
// depends on spcd_pkg; bound to the top level below
`timescale 1ns / 1ps

module spcd_assertions (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         data_byte,
  input logic               end_of_packet,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [31:0]        time_ms,
  input logic signed [15:0] force_tenths,
  input logic signed [15:0] roll_tenths,
  input logic signed [15:0] pitch_tenths,
  input logic [7:0]         battery_level
);

  // a stalled result holds its status
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // only defined status codes are shown
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == spcd_pkg::STATUS_OK || status == spcd_pkg::STATUS_CRC_ERR
                   || status == spcd_pkg::STATUS_LEN_ERR))
    else $error("undefined status code");

  // failed packets carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != spcd_pkg::STATUS_OK |->
      time_ms == 32'd0 && force_tenths == 16'sd0 && roll_tenths == 16'sd0
      && pitch_tenths == 16'sd0 && battery_level == 8'd0)
    else $error("failed packet with nonzero fields");

  // input is never blocked while no result waits
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a non-final item never makes a result appear
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && end_of_packet) |=> !out_valid)
    else $error("result without final byte");

endmodule

bind sensor_packet_crc8_deframer spcd_assertions u_spcd_assertions (.*);
